>>> rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  localparam int OPCODE_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int POS_W       = 11;
  localparam int DATA_W      = 16;
  localparam int COLOR_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_CURSOR = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORE = 1'b0,
    CFG_BACK = 1'b1
  } cfg_reg_t;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic cnt_clr;
    logic clr_wr;
    logic scr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    scroll_req;
    logic    cnt_last;
  } sts_t;

endpackage

>>> rtl/text_console_writer_core.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_tvalid/tready   | tuser opcode; tdata char, hold, cell index
// out_    | output    | out_tvalid/tready  | tdata cursor_pos, cursor_update, read_data
// cfg_    | input     | cfg_valid/ready    | cfg_index register, cfg_data color nibble
//
// Put, newline, backspace, read and cursor report pass through accept, execute and load output.
// A scroll steps through all ROWS*COLUMNS cells, a clear writes all of them, one cell per
// cycle through the single write port of the cell memory.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with in_tready low.
// The output register lets the next item be taken while a result waits; a held result
// stalls only the completion of the following item.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] char_code, [8] hold_cursor, [19:9] cell_index, [23:20] zero
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [tcw_pkg::OPCODE_W-1:0]    in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [10:0] cursor_pos, [11] cursor_update, [27:12] read_data, [31:28] zero
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_tdata(out_tdata)
  );

endmodule

>>> rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (sts.op == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if (sts.scroll_req) begin
          state_nxt = ST_SCROLL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.scr_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

>>> rtl/tcw_datapath.sv
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [tcw_pkg::OPCODE_W-1:0]     in_tuser,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
  input  tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::sts_t                    sts,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tcw_pkg::*;

  localparam int CellCount = COLUMNS * ROWS;
  localparam int CopyCount = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W    = $clog2(CellCount);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);

  logic [DATA_W-1:0] mem [CellCount];

  opcode_t            op_r;
  logic [CHAR_W-1:0]  char_r;
  logic               hold_r;
  logic [IDX_W-1:0]   idx_r;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COLOR_W-1:0] fore_r, back_r;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic               pend_v_r;
  logic               pend_zero_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic               upd_r, upd_nxt;
  logic               rd_hit_r, rd_hit_nxt;
  logic [DATA_W-1:0]  rd_data_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [ADDR_W-1:0]  pos;
  logic               col_last, row_last;
  logic               is_nl, is_bs, is_wr;
  logic               rd_hit_c, copy;
  logic               we, re;
  logic [ADDR_W-1:0]  wa, ra;
  logic [DATA_W-1:0]  wd;
  logic [DATA_W-1:0]  read_data;

  assign pos      = ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r));
  assign col_last = (col_r == COL_W'(COLUMNS - 1));
  assign row_last = (row_r == ROW_W'(ROWS - 1));
  assign is_nl    = (op_r == OP_PUT) && (char_r == CH_NEWLINE);
  assign is_bs    = (op_r == OP_PUT) && (char_r == CH_BACKSPACE);
  assign is_wr    = (op_r == OP_PUT) && !is_nl && !is_bs;
  assign rd_hit_c = (op_r == OP_READ) && (32'(idx_r) < CellCount);
  assign copy     = (32'(cnt_r) < CopyCount);

  assign sts.op         = op_r;
  assign sts.scroll_req = row_last && (is_nl || (is_wr && col_last));
  assign sts.cnt_last   = (cnt_r == ADDR_W'(CellCount - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= opcode_t'(in_tuser);
      char_r <= in_tdata[7:0];
      hold_r <= in_tdata[8];
      idx_r  <= in_tdata[19:9];
    end
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    upd_nxt    = upd_r;
    rd_hit_nxt = rd_hit_r;
    if (cmd.exec) begin
      upd_nxt    = 1'b0;
      rd_hit_nxt = rd_hit_c;
      case (op_r)
        OP_PUT: begin
          if (is_nl) begin
            col_nxt = '0;
            if (!row_last) begin
              row_nxt = row_r + 1'b1;
            end
            upd_nxt = !hold_r;
          end else if (is_bs) begin
            if (col_r != '0) begin
              col_nxt = col_r - 1'b1;
            end else if (row_r != '0) begin
              row_nxt = row_r - 1'b1;
              col_nxt = COL_W'(COLUMNS - 1);
            end
          end else begin
            upd_nxt = !hold_r;
            if (col_last) begin
              col_nxt = '0;
              if (!row_last) begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
          upd_nxt = 1'b1;
        end
        OP_READ: begin
          upd_nxt = 1'b0;
        end
        OP_CURSOR: begin
          upd_nxt = 1'b1;
        end
        default: begin
          upd_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.clr_wr || cmd.scr_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      fore_r   <= COLOR_W'(7);
      back_r   <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= cmd.scr_step;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_FORE: fore_r <= cfg_data;
          CFG_BACK: back_r <= cfg_data;
          default:  fore_r <= fore_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_r       <= upd_nxt;
    rd_hit_r    <= rd_hit_nxt;
    pend_addr_r <= cnt_r;
    pend_zero_r <= !copy;
  end

  // single write port, one registered read port
  always_comb begin
    we = 1'b0;
    wa = pos;
    wd = '0;
    if (cmd.exec && is_wr) begin
      we = 1'b1;
      wd = {back_r, fore_r, char_r};
    end else if (cmd.clr_wr) begin
      we = 1'b1;
      wa = cnt_r;
    end else if (pend_v_r) begin
      we = 1'b1;
      wa = pend_addr_r;
      wd = pend_zero_r ? '0 : rd_data_r;
    end
  end

  assign re = (cmd.exec && rd_hit_c) || (cmd.scr_step && copy);
  assign ra = cmd.exec ? ADDR_W'(idx_r) : ADDR_W'(32'(cnt_r) + COLUMNS);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign read_data = rd_hit_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_TDATA_W'({read_data, upd_r, POS_W'(pos)});
    end
  end

  assign out_tdata = out_data_r;

endmodule

>>> rtl/tcw_checker.sv
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken before the first finished");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (COLUMNS * ROWS > 2048) || (32'(out_tdata[10:0]) < COLUMNS * ROWS))
    else $error("cursor position outside the screen");

  a_read_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[27:12] != 16'h0000) |-> !out_tdata[11])
    else $error("cell read reported a cursor update");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
